// ----- hdl/hdld_pkg.sv -----
`timescale 1ns / 1ps
// hdld_pkg: shared types and constants for the hex dump line decoder.
// No dependencies; imported by hdld_parse, hex_dump_line_decoder and hdld_checker.
package hdld_pkg;

	// Parser phase
	typedef enum logic [2:0] {
		PH_OFFSET = 3'd0,
		PH_GAP    = 3'd1,
		PH_HEX    = 3'd2,
		PH_SKIP   = 3'd3,
		PH_HALT   = 3'd4,
		PH_DONE   = 3'd5
	} phase_t;

	// Result kinds
	localparam logic [1:0] KIND_DATA   = 2'd0;
	localparam logic [1:0] KIND_BADOFS = 2'd1;
	localparam logic [1:0] KIND_END    = 2'd2;

	// Character codes
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_DASH  = 8'd45;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;

	// One result beat from the parser
	typedef struct packed {
		logic        emit;
		logic [7:0]  data_byte;
		logic [1:0]  kind;
		logic [31:0] found_offset;
		logic        last;
	} res_t;

endpackage

// ----- hdl/hdld_parse.sv -----
`timescale 1ns / 1ps
// hdld_parse: line parser state and its per-character next-state logic.
// Depends on hdld_pkg.
module hdld_parse
	import hdld_pkg::*;
#(
	parameter int OFFSET_DIGITS       = 8,
	parameter int HEX_DIGITS_PER_LINE = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic [7:0] text_char,
	input  logic       end_of_input,
	output res_t       res
);

	localparam int OCW = $clog2(OFFSET_DIGITS + 1);
	localparam int HCW = $clog2(HEX_DIGITS_PER_LINE);

	// Value of a digit character; anything else counts as zero
	function automatic logic [3:0] digit_value(input logic [7:0] c);
		logic [7:0] t;
		begin
			t = 8'd0;
			if (c inside {[8'd48:8'd57]}) begin
				t = c - 8'd48;
			end else if (c inside {[8'd97:8'd102]}) begin
				t = c - 8'd87;
			end
			digit_value = t[3:0];
		end
	endfunction

	phase_t           phase_q, phase_n;
	logic [31:0]      accum_q, accum_n;
	logic [OCW-1:0]   ocnt_q, ocnt_n;
	logic [HCW-1:0]   hcnt_q, hcnt_n;
	logic [3:0]       high_q, high_n;
	logic [1:0]       srun_q, srun_n;
	logic             dash_q, dash_n;
	logic [27:0]      line_q, line_n;

	logic             is_sp, is_dash, is_lf, is_cr;
	logic [3:0]       dv;
	logic [31:0]      acc_sh;
	logic [OCW-1:0]   ocnt_inc;
	logic [31:0]      chk_acc;
	logic [OCW-1:0]   chk_cnt;
	logic [OCW-1:0]   missing;
	logic [OCW+1:0]   shamt;
	logic [31:0]      found;
	logic             ofs_ok;
	logic [HCW:0]     hcnt_inc;
	logic [1:0]       srun_inc;

	// Character classes and shared datapath terms
	always_comb begin
		is_sp    = (text_char == CH_SPACE);
		is_dash  = (text_char == CH_DASH);
		is_lf    = (text_char == CH_LF);
		is_cr    = (text_char == CH_CR);
		dv       = digit_value(text_char);
		acc_sh   = {accum_q[27:0], dv};
		ocnt_inc = ocnt_q + 1'b1;
		// A space closes a short field with the digits so far
		chk_acc  = is_sp ? accum_q : acc_sh;
		chk_cnt  = is_sp ? ocnt_q : ocnt_inc;
		missing  = OCW'(OFFSET_DIGITS) - chk_cnt;
		shamt    = {missing, 2'b00};
		found    = chk_acc << shamt;
		ofs_ok   = (found == {line_q, 4'h0});
		hcnt_inc = {1'b0, hcnt_q} + 1'b1;
		srun_inc = (srun_q == 2'd2) ? 2'd2 : srun_q + 2'd1;
	end

	// Next state and result for one character
	always_comb begin
		phase_n = phase_q;
		accum_n = accum_q;
		ocnt_n  = ocnt_q;
		hcnt_n  = hcnt_q;
		high_n  = high_q;
		srun_n  = srun_q;
		dash_n  = dash_q;
		line_n  = line_q;
		res     = '0;

		if (phase_q == PH_HALT || phase_q == PH_DONE) begin
			// stopped: ignore everything
		end else if (end_of_input) begin
			phase_n   = PH_DONE;
			res.emit  = 1'b1;
			res.kind  = KIND_END;
			res.last  = 1'b1;
		end else begin
			case (phase_q)
				PH_OFFSET: begin
					if (ocnt_q == '0 && (is_sp || is_cr || is_lf)) begin
						// leading blanks and empty lines
					end else if (is_sp || ocnt_inc >= OCW'(OFFSET_DIGITS)) begin
						if (!is_sp) begin
							accum_n = acc_sh;
							ocnt_n  = ocnt_inc;
						end
						if (ofs_ok) begin
							phase_n = PH_GAP;
						end else begin
							phase_n          = PH_HALT;
							res.emit         = 1'b1;
							res.kind         = KIND_BADOFS;
							res.found_offset = found;
							res.last         = 1'b1;
						end
					end else begin
						accum_n = acc_sh;
						ocnt_n  = ocnt_inc;
					end
				end
				PH_GAP, PH_HEX: begin
					if (is_lf) begin
						// next line
						line_n  = line_q + 28'd1;
						phase_n = PH_OFFSET;
						accum_n = '0;
						ocnt_n  = '0;
						hcnt_n  = '0;
						high_n  = '0;
						srun_n  = '0;
						dash_n  = 1'b0;
					end else if (is_cr) begin
						phase_n = PH_SKIP;
					end else if (phase_q == PH_GAP && (is_sp || is_dash)) begin
						// gap after offset
					end else if (is_sp) begin
						srun_n = srun_inc;
						if (srun_inc == 2'd2 && !dash_q) begin
							phase_n = PH_SKIP;
						end
					end else if (is_dash) begin
						dash_n = 1'b1;
					end else begin
						// hex digit
						phase_n = PH_HEX;
						srun_n  = '0;
						dash_n  = 1'b0;
						if (!hcnt_q[0]) begin
							high_n = dv;
						end else begin
							res.emit      = 1'b1;
							res.kind      = KIND_DATA;
							res.data_byte = {high_q, dv};
						end
						if (hcnt_inc >= (HCW+1)'(HEX_DIGITS_PER_LINE)) begin
							hcnt_n  = '0;
							phase_n = PH_SKIP;
						end else begin
							hcnt_n = hcnt_inc[HCW-1:0];
						end
					end
				end
				PH_SKIP: begin
					if (is_lf) begin
						line_n  = line_q + 28'd1;
						phase_n = PH_OFFSET;
						accum_n = '0;
						ocnt_n  = '0;
						hcnt_n  = '0;
						high_n  = '0;
						srun_n  = '0;
						dash_n  = 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OFFSET;
			accum_q <= '0;
			ocnt_q  <= '0;
			hcnt_q  <= '0;
			high_q  <= '0;
			srun_q  <= '0;
			dash_q  <= 1'b0;
			line_q  <= '0;
		end else if (adv) begin
			phase_q <= phase_n;
			accum_q <= accum_n;
			ocnt_q  <= ocnt_n;
			hcnt_q  <= hcnt_n;
			high_q  <= high_n;
			srun_q  <= srun_n;
			dash_q  <= dash_n;
			line_q  <= line_n;
		end
	end

endmodule

// ----- hdl/hex_dump_line_decoder.sv -----
`timescale 1ns / 1ps
// hex_dump_line_decoder: top level, input register, parser and result register.
// A character passes from the input register through the parser into the result register, which drives out_valid.
// Throughput: one character per cycle unless a result waits on out_ready; the parser state updates once per beat.
// Reset (arst_n low, async) empties both registers and returns to offset field, line 0.
// Depends on hdld_pkg and hdld_parse.
module hex_dump_line_decoder
	import hdld_pkg::*;
#(
	parameter int OFFSET_DIGITS       = 8,
	parameter int HEX_DIGITS_PER_LINE = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  text_char,
	input  logic        end_of_input,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  data_byte,
	output logic [1:0]  kind,
	output logic [31:0] found_offset,
	output logic        last
);

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        eoi_s1;
	logic        adv;
	res_t        res;
	logic        out_valid_q;
	logic [7:0]  data_byte_q;
	logic [1:0]  kind_q;
	logic [31:0] found_offset_q;
	logic        last_q;

	// Stage moves on when it makes no result or the result register has room
	assign adv      = valid_s1 && (!res.emit || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= text_char;
			eoi_s1  <= end_of_input;
		end
	end

	hdld_parse #(
		.OFFSET_DIGITS       (OFFSET_DIGITS),
		.HEX_DIGITS_PER_LINE (HEX_DIGITS_PER_LINE)
	) u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.text_char    (char_s1),
		.end_of_input (eoi_s1),
		.res          (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.emit) begin
			data_byte_q    <= res.data_byte;
			kind_q         <= res.kind;
			found_offset_q <= res.found_offset;
			last_q         <= res.last;
		end
	end

	assign out_valid    = out_valid_q;
	assign data_byte    = data_byte_q;
	assign kind         = kind_q;
	assign found_offset = found_offset_q;
	assign last         = last_q;

endmodule

// ----- hdl/hdld_checker.sv -----
`timescale 1ns / 1ps
// hdld_checker: port-level assertions for hex_dump_line_decoder, bound to the top level.
// Depends on hdld_pkg.
module hdld_checker
	import hdld_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  data_byte,
	input logic [1:0]  kind,
	input logic [31:0] found_offset,
	input logic        last
);

	logic finished_q;

	// Remember that a final beat has gone out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			finished_q <= 1'b0;
		end else if (out_valid && out_ready && last) begin
			finished_q <= 1'b1;
		end
	end

	// Nothing follows a final beat
	a_no_beat_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		!(finished_q && out_valid))
		else $error("result beat after last");

	// Stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(kind)
			&& $stable(found_offset) && $stable(last))
		else $error("stalled result changed");

	// Data beats are never final and carry no offset
	a_data_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_DATA |-> !last && found_offset == 32'd0)
		else $error("bad data beat fields");

	// Mismatch and end beats are final and carry no byte
	a_stop_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_DATA |-> last && data_byte == 8'd0)
		else $error("bad stop beat fields");

endmodule

bind hex_dump_line_decoder hdld_checker u_hdld_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.data_byte    (data_byte),
	.kind         (kind),
	.found_offset (found_offset),
	.last         (last)
);
